// ===== hdl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Types and constants shared by the source text tokenizer modules.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned LEN_W       = 6;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned NUM_KW      = 7;

  typedef enum logic [4:0] {
    TK_LBRACE        = 5'd0,
    TK_RBRACE        = 5'd1,
    TK_LPAREN        = 5'd2,
    TK_RPAREN        = 5'd3,
    TK_LBRACKET      = 5'd4,
    TK_RBRACKET      = 5'd5,
    TK_PLUS          = 5'd6,
    TK_MINUS         = 5'd7,
    TK_STAR          = 5'd8,
    TK_BACKSLASH     = 5'd9,
    TK_EQUAL         = 5'd10,
    TK_NOT_EQUAL     = 5'd11,
    TK_GREATER       = 5'd12,
    TK_GREATER_EQUAL = 5'd13,
    TK_LESS          = 5'd14,
    TK_LESS_EQUAL    = 5'd15,
    TK_IF            = 5'd16,
    TK_WHILE         = 5'd17,
    TK_VAR           = 5'd18,
    TK_PRINT         = 5'd19,
    TK_FUNC          = 5'd20,
    TK_END           = 5'd21,
    TK_ID_CHAR       = 5'd22,
    TK_INT           = 5'd23,
    TK_BOOL          = 5'd24,
    TK_STR_CHAR      = 5'd25,
    TK_STR_END       = 5'd26,
    TK_ASSIGN        = 5'd27,
    TK_AND           = 5'd28,
    TK_OR            = 5'd29,
    TK_ERROR         = 5'd30
  } tok_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_COLON    = 3'd1,
    ERR_BANG     = 3'd2,
    ERR_UNKNOWN  = 3'd3,
    ERR_UNCLOSED = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUMBER,
    MODE_STRING
  } mode_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_COLON,
    OP_BANG,
    OP_EQUAL,
    OP_GREATER,
    OP_LESS
  } op_e;

  typedef enum logic [1:0] {
    MID_NONE,
    MID_TOK,
    MID_DRAIN
  } mid_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_MID,
    ST_DRAIN,
    ST_LAST
  } back_state_e;

  typedef struct packed {
    tok_kind_e kind;
    err_e      err;
  } tok_t;

  // work for one accepted beat: an optional leading token, an optional middle
  // part (single token or identifier drain) and an optional trailing token
  typedef struct packed {
    logic             first_v;
    tok_t             first;
    mid_e             mid;
    tok_t             mid_tok;
    logic [31:0]      value;
    logic [LEN_W-1:0] len;
    logic             ovf;
    logic             last_v;
    tok_t             last;
    logic [7:0]       text;
    logic [31:0]      line;
  } cmd_t;

  localparam logic [7:0] KW_TEXT [NUM_KW][5] = '{
    '{"i", "f", 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e"},
    '{"v", "a", "r", 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t"},
    '{"f", "u", "n", "c", 8'h00},
    '{"t", "r", "u", "e", 8'h00},
    '{"f", "a", "l", "s", "e"}
  };

  localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
    LEN_W'(2), LEN_W'(5), LEN_W'(3), LEN_W'(5), LEN_W'(4), LEN_W'(4), LEN_W'(5)
  };

  localparam tok_kind_e KW_KIND [NUM_KW] = '{
    TK_IF, TK_WHILE, TK_VAR, TK_PRINT, TK_FUNC, TK_BOOL, TK_BOOL
  };

  localparam logic KW_VALUE [NUM_KW] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

endpackage

// ===== hdl/stt_in_if.sv =====
// ----------------------------------------------------------------------------
// stt_in_if
// Source byte channel: valid/ready handshake with kind and byte payload.
// ----------------------------------------------------------------------------
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_byte;

  modport source (output valid, output kind, output char_byte, input ready);
  modport sink   (input valid, input kind, input char_byte, output ready);
endinterface

// ===== hdl/stt_out_if.sv =====
// ----------------------------------------------------------------------------
// stt_out_if
// Token channel: valid/ready handshake with one token per beat.
// ----------------------------------------------------------------------------
interface stt_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         token_kind;
  logic signed [31:0] token_value;
  logic [7:0]         text_char;
  logic               text_last;
  logic [2:0]         error_code;
  logic [31:0]        error_line;
  logic               run_last;

  modport source (
    output valid, output token_kind, output token_value, output text_char,
    output text_last, output error_code, output error_line, output run_last,
    input ready
  );
  modport sink (
    input valid, input token_kind, input token_value, input text_char,
    input text_last, input error_code, input error_line, input run_last,
    output ready
  );
endinterface

// ===== hdl/stt_ram.sv =====
// ----------------------------------------------------------------------------
// stt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 32,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/stt_fifo.sv =====
// ----------------------------------------------------------------------------
// stt_fifo
// Short command queue between the scanning front and the token back end.
// ----------------------------------------------------------------------------
module stt_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  stt_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output stt_pkg::cmd_t head_o,
  output logic          empty_o
);

  localparam int unsigned PW = $clog2(stt_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(stt_pkg::QUEUE_DEPTH + 1);

  stt_pkg::cmd_t   slot_q [stt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(stt_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(stt_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front
// Scanner front end: takes source beats, tracks the lexer state, fills the
// word buffer and queues one command per beat that produces tokens.
// ----------------------------------------------------------------------------
module stt_front #(
  parameter  int unsigned MAX_WORD = 32,
  localparam int unsigned AW       = $clog2(MAX_WORD)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  stt_in_if.sink        src_i,
  input  logic          full_i,
  input  logic          drain_done_i,
  output logic          push_o,
  output stt_pkg::cmd_t cmd_o,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output logic [7:0]    wdata_o
);

  localparam int unsigned LW = stt_pkg::LEN_W;
  localparam int unsigned KN = stt_pkg::NUM_KW;

  stt_pkg::mode_e  mode_q, mode_d;
  stt_pkg::op_e    pend_q, pend_d;
  logic [LW-1:0]   len_q, len_d;
  logic            ovf_q, ovf_d;
  logic [31:0]     num_q, num_d;
  logic [31:0]     line_q, line_d;
  logic [KN-1:0]   kw_q, kw_d;
  logic            busy_q, busy_d;

  logic            accept;
  logic [7:0]      c;
  logic            is_letter, is_digit;

  logic            si_v;
  stt_pkg::tok_t   si_tok;
  stt_pkg::op_e    si_pend;
  logic            si_str, si_word, si_num, si_nl;
  logic            apply_si;

  logic            kw_hit;
  stt_pkg::tok_kind_e kw_kind;
  logic            kw_val;

  stt_pkg::cmd_t   cmd;

  assign src_i.ready = !busy_q && !full_i;
  assign accept      = src_i.valid && src_i.ready;
  assign c           = src_i.char_byte;
  assign is_letter   = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit    = (c >= "0" && c <= "9");

  function automatic logic [KN-1:0] kw_next(input logic [KN-1:0] ok,
                                            input logic [LW-1:0] pos,
                                            input logic [7:0] ch);
    logic [KN-1:0] r;
    r = '0;
    for (int k = 0; k < KN; k++) begin
      r[k] = ok[k] && (pos < stt_pkg::KW_LEN[k]) && (stt_pkg::KW_TEXT[k][pos[2:0]] == ch);
    end
    return r;
  endfunction

  function automatic stt_pkg::tok_t pend_alone(input stt_pkg::op_e op);
    stt_pkg::tok_t t;
    unique case (op)
      stt_pkg::OP_COLON:   t = '{kind: stt_pkg::TK_ERROR,   err: stt_pkg::ERR_COLON};
      stt_pkg::OP_BANG:    t = '{kind: stt_pkg::TK_ERROR,   err: stt_pkg::ERR_BANG};
      stt_pkg::OP_EQUAL:   t = '{kind: stt_pkg::TK_ASSIGN,  err: stt_pkg::ERR_NONE};
      stt_pkg::OP_GREATER: t = '{kind: stt_pkg::TK_GREATER, err: stt_pkg::ERR_NONE};
      stt_pkg::OP_LESS:    t = '{kind: stt_pkg::TK_LESS,    err: stt_pkg::ERR_NONE};
      default:             t = '{kind: stt_pkg::TK_END,     err: stt_pkg::ERR_NONE};
    endcase
    return t;
  endfunction

  function automatic stt_pkg::tok_t pend_join(input stt_pkg::op_e op);
    stt_pkg::tok_t t;
    t.err = stt_pkg::ERR_NONE;
    unique case (op)
      stt_pkg::OP_COLON:   t.kind = stt_pkg::TK_ASSIGN;
      stt_pkg::OP_BANG:    t.kind = stt_pkg::TK_NOT_EQUAL;
      stt_pkg::OP_EQUAL:   t.kind = stt_pkg::TK_EQUAL;
      stt_pkg::OP_GREATER: t.kind = stt_pkg::TK_GREATER_EQUAL;
      stt_pkg::OP_LESS:    t.kind = stt_pkg::TK_LESS_EQUAL;
      default:             t.kind = stt_pkg::TK_END;
    endcase
    return t;
  endfunction

  // classification of a byte seen with no token in progress
  always_comb begin
    si_v    = 1'b0;
    si_tok  = '{kind: stt_pkg::TK_LBRACE, err: stt_pkg::ERR_NONE};
    si_pend = stt_pkg::OP_NONE;
    si_str  = 1'b0;
    si_word = 1'b0;
    si_num  = 1'b0;
    si_nl   = 1'b0;
    unique case (c)
      " ", "\t": ;
      "\n": si_nl = 1'b1;
      "{":  begin si_v = 1'b1; si_tok.kind = stt_pkg::TK_LBRACE;    end
      "}":  begin si_v = 1'b1; si_tok.kind = stt_pkg::TK_RBRACE;    end
      "(":  begin si_v = 1'b1; si_tok.kind = stt_pkg::TK_LPAREN;    end
      ")":  begin si_v = 1'b1; si_tok.kind = stt_pkg::TK_RPAREN;    end
      "[":  begin si_v = 1'b1; si_tok.kind = stt_pkg::TK_LBRACKET;  end
      "]":  begin si_v = 1'b1; si_tok.kind = stt_pkg::TK_RBRACKET;  end
      "+":  begin si_v = 1'b1; si_tok.kind = stt_pkg::TK_PLUS;      end
      "-":  begin si_v = 1'b1; si_tok.kind = stt_pkg::TK_MINUS;     end
      "*":  begin si_v = 1'b1; si_tok.kind = stt_pkg::TK_STAR;      end
      "\\": begin si_v = 1'b1; si_tok.kind = stt_pkg::TK_BACKSLASH; end
      "&":  begin si_v = 1'b1; si_tok.kind = stt_pkg::TK_AND;       end
      "|":  begin si_v = 1'b1; si_tok.kind = stt_pkg::TK_OR;        end
      ":":  si_pend = stt_pkg::OP_COLON;
      "!":  si_pend = stt_pkg::OP_BANG;
      "=":  si_pend = stt_pkg::OP_EQUAL;
      ">":  si_pend = stt_pkg::OP_GREATER;
      "<":  si_pend = stt_pkg::OP_LESS;
      "\"": si_str = 1'b1;
      default: begin
        if (is_letter) begin
          si_word = 1'b1;
        end else if (is_digit) begin
          si_num = 1'b1;
        end else begin
          si_v   = 1'b1;
          si_tok = '{kind: stt_pkg::TK_ERROR, err: stt_pkg::ERR_UNKNOWN};
        end
      end
    endcase
  end

  // keyword check on the word held so far
  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = stt_pkg::TK_IF;
    kw_val  = 1'b0;
    for (int k = 0; k < KN; k++) begin
      if (kw_q[k] && len_q == stt_pkg::KW_LEN[k] && !ovf_q) begin
        kw_hit  = 1'b1;
        kw_kind = stt_pkg::KW_KIND[k];
        kw_val  = stt_pkg::KW_VALUE[k];
      end
    end
  end

  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    num_d    = num_q;
    line_d   = line_q;
    kw_d     = kw_q;
    apply_si = 1'b0;
    we_o     = 1'b0;
    waddr_o  = len_q[AW-1:0];
    wdata_o  = c;
    cmd      = '0;
    cmd.line = line_q;

    if (accept) begin
      if (src_i.kind) begin
        if (pend_q != stt_pkg::OP_NONE) begin
          cmd.first_v = 1'b1;
          cmd.first   = pend_alone(pend_q);
        end
        unique case (mode_q)
          stt_pkg::MODE_WORD: begin
            if (kw_hit) begin
              cmd.mid     = stt_pkg::MID_TOK;
              cmd.mid_tok = '{kind: kw_kind, err: stt_pkg::ERR_NONE};
              cmd.value   = {31'd0, kw_val};
            end else begin
              cmd.mid = stt_pkg::MID_DRAIN;
              cmd.len = len_q;
              cmd.ovf = ovf_q;
            end
          end
          stt_pkg::MODE_NUMBER: begin
            cmd.mid     = stt_pkg::MID_TOK;
            cmd.mid_tok = '{kind: stt_pkg::TK_INT, err: stt_pkg::ERR_NONE};
            cmd.value   = num_q;
          end
          stt_pkg::MODE_STRING: begin
            cmd.mid     = stt_pkg::MID_TOK;
            cmd.mid_tok = '{kind: stt_pkg::TK_ERROR, err: stt_pkg::ERR_UNCLOSED};
          end
          default: ;
        endcase
        cmd.last_v = 1'b1;
        cmd.last   = '{kind: stt_pkg::TK_END, err: stt_pkg::ERR_NONE};
        mode_d     = stt_pkg::MODE_IDLE;
        pend_d     = stt_pkg::OP_NONE;
        len_d      = '0;
        ovf_d      = 1'b0;
        num_d      = '0;
        line_d     = '0;
      end else if (pend_q != stt_pkg::OP_NONE) begin
        cmd.first_v = 1'b1;
        pend_d      = stt_pkg::OP_NONE;
        if (c == "=") begin
          cmd.first = pend_join(pend_q);
        end else begin
          cmd.first = pend_alone(pend_q);
          apply_si  = 1'b1;
        end
      end else begin
        unique case (mode_q)
          stt_pkg::MODE_WORD: begin
            if (is_letter) begin
              if (len_q < LW'(MAX_WORD)) begin
                we_o  = 1'b1;
                len_d = len_q + LW'(1);
                kw_d  = kw_next(kw_q, len_q, c);
              end else begin
                ovf_d = 1'b1;
              end
            end else begin
              if (kw_hit) begin
                cmd.mid     = stt_pkg::MID_TOK;
                cmd.mid_tok = '{kind: kw_kind, err: stt_pkg::ERR_NONE};
                cmd.value   = {31'd0, kw_val};
              end else begin
                cmd.mid = stt_pkg::MID_DRAIN;
                cmd.len = len_q;
                cmd.ovf = ovf_q;
              end
              len_d    = '0;
              ovf_d    = 1'b0;
              mode_d   = stt_pkg::MODE_IDLE;
              apply_si = 1'b1;
            end
          end
          stt_pkg::MODE_NUMBER: begin
            if (is_digit) begin
              num_d = {num_q[28:0], 3'b000} + {num_q[30:0], 1'b0} + {28'd0, c[3:0]};
            end else begin
              cmd.mid     = stt_pkg::MID_TOK;
              cmd.mid_tok = '{kind: stt_pkg::TK_INT, err: stt_pkg::ERR_NONE};
              cmd.value   = num_q;
              num_d       = '0;
              mode_d      = stt_pkg::MODE_IDLE;
              apply_si    = 1'b1;
            end
          end
          stt_pkg::MODE_STRING: begin
            cmd.last_v = 1'b1;
            if (c == "\"") begin
              cmd.last = '{kind: stt_pkg::TK_STR_END, err: stt_pkg::ERR_NONE};
              mode_d   = stt_pkg::MODE_IDLE;
            end else begin
              cmd.last = '{kind: stt_pkg::TK_STR_CHAR, err: stt_pkg::ERR_NONE};
              cmd.text = c;
            end
          end
          default: apply_si = 1'b1;
        endcase
      end

      if (apply_si) begin
        if (si_v) begin
          cmd.last_v = 1'b1;
          cmd.last   = si_tok;
        end
        if (si_pend != stt_pkg::OP_NONE) begin
          pend_d = si_pend;
        end
        if (si_str) begin
          mode_d = stt_pkg::MODE_STRING;
        end
        if (si_word) begin
          mode_d  = stt_pkg::MODE_WORD;
          we_o    = 1'b1;
          waddr_o = '0;
          len_d   = LW'(1);
          ovf_d   = 1'b0;
          kw_d    = kw_next('1, '0, c);
        end
        if (si_num) begin
          mode_d = stt_pkg::MODE_NUMBER;
          num_d  = {28'd0, c[3:0]};
        end
        if (si_nl) begin
          line_d = line_q + 32'd1;
        end
      end
    end

    push_o = accept && (cmd.first_v || cmd.mid != stt_pkg::MID_NONE || cmd.last_v);
    cmd_o  = cmd;

    // hold input while buffered identifier characters are read out
    busy_d = busy_q;
    if (drain_done_i) begin
      busy_d = 1'b0;
    end
    if (push_o && cmd.mid == stt_pkg::MID_DRAIN) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= stt_pkg::MODE_IDLE;
      pend_q <= stt_pkg::OP_NONE;
      len_q  <= '0;
      ovf_q  <= 1'b0;
      num_q  <= '0;
      line_q <= '0;
      kw_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      num_q  <= num_d;
      line_q <= line_d;
      kw_q   <= kw_d;
      busy_q <= busy_d;
    end
  end

endmodule

// ===== hdl/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back
// Token back end: walks each queued command and emits its tokens, one beat per
// cycle while tok_o is ready, reading identifier characters from the word buffer.
// ----------------------------------------------------------------------------
module stt_back #(
  parameter  int unsigned MAX_WORD = 32,
  localparam int unsigned AW       = $clog2(MAX_WORD)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stt_pkg::cmd_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          drain_done_o,
  output logic [AW-1:0] raddr_o,
  input  logic [7:0]    rdata_i,
  stt_out_if.source     tok_o
);

  localparam int unsigned LW = stt_pkg::LEN_W;

  stt_pkg::back_state_e state_q, state_d, after;
  stt_pkg::cmd_t        cur_q, cur_d;
  logic [LW-1:0]        idx_q, idx_d;
  logic                 adv, emit, fin, at_end;

  logic                 out_valid_q, out_valid_d;
  stt_pkg::tok_kind_e   res_kind, kind_q;
  logic [31:0]          res_value, value_q;
  logic [7:0]           res_text, text_q;
  logic                 res_tlast, tlast_q;
  stt_pkg::err_e        res_err, err_q;
  logic [31:0]          res_line, line_q;
  logic                 run_last_q;

  function automatic stt_pkg::back_state_e entry(input stt_pkg::cmd_t cmd);
    stt_pkg::back_state_e s;
    if (cmd.first_v) begin
      s = stt_pkg::ST_FIRST;
    end else if (cmd.mid == stt_pkg::MID_TOK) begin
      s = stt_pkg::ST_MID;
    end else if (cmd.mid == stt_pkg::MID_DRAIN) begin
      s = stt_pkg::ST_DRAIN;
    end else begin
      s = stt_pkg::ST_LAST;
    end
    return s;
  endfunction

  assign adv    = !out_valid_q || tok_o.ready;
  assign emit   = adv && (state_q != stt_pkg::ST_IDLE);
  assign at_end = (idx_q == cur_q.len - LW'(1));

  // next state
  always_comb begin
    unique case (state_q)
      stt_pkg::ST_FIRST: begin
        if (cur_q.mid == stt_pkg::MID_TOK) begin
          after = stt_pkg::ST_MID;
        end else if (cur_q.mid == stt_pkg::MID_DRAIN) begin
          after = stt_pkg::ST_DRAIN;
        end else if (cur_q.last_v) begin
          after = stt_pkg::ST_LAST;
        end else begin
          after = stt_pkg::ST_IDLE;
        end
      end
      stt_pkg::ST_MID:   after = cur_q.last_v ? stt_pkg::ST_LAST : stt_pkg::ST_IDLE;
      stt_pkg::ST_DRAIN: begin
        if (!at_end) begin
          after = stt_pkg::ST_DRAIN;
        end else begin
          after = cur_q.last_v ? stt_pkg::ST_LAST : stt_pkg::ST_IDLE;
        end
      end
      stt_pkg::ST_LAST:  after = stt_pkg::ST_IDLE;
      default:           after = stt_pkg::ST_IDLE;
    endcase

    fin     = emit && (after == stt_pkg::ST_IDLE);
    state_d = emit ? after : state_q;
    cur_d   = cur_q;
    pop_o   = ((state_q == stt_pkg::ST_IDLE) || fin) && !empty_i;
    if (pop_o) begin
      state_d = entry(head_i);
      cur_d   = head_i;
    end

    // read address is taken from idx_d so the registered read data lines up with idx_q
    idx_d = '0;
    if (state_d == stt_pkg::ST_DRAIN && state_q == stt_pkg::ST_DRAIN) begin
      idx_d = emit ? idx_q + LW'(1) : idx_q;
    end
  end

  assign raddr_o      = idx_d[AW-1:0];
  assign drain_done_o = emit && (state_q == stt_pkg::ST_DRAIN) && at_end;

  // token fields
  always_comb begin
    res_kind  = stt_pkg::TK_END;
    res_value = '0;
    res_text  = '0;
    res_tlast = 1'b0;
    res_err   = stt_pkg::ERR_NONE;
    unique case (state_q)
      stt_pkg::ST_FIRST: begin
        res_kind = cur_q.first.kind;
        res_err  = cur_q.first.err;
      end
      stt_pkg::ST_MID: begin
        res_kind  = cur_q.mid_tok.kind;
        res_err   = cur_q.mid_tok.err;
        res_value = cur_q.value;
      end
      stt_pkg::ST_DRAIN: begin
        res_kind  = stt_pkg::TK_ID_CHAR;
        res_value = {31'd0, cur_q.ovf};
        res_text  = rdata_i;
        res_tlast = at_end;
      end
      stt_pkg::ST_LAST: begin
        res_kind = cur_q.last.kind;
        res_err  = cur_q.last.err;
        res_text = cur_q.text;
      end
      default: ;
    endcase
    res_line    = (res_kind == stt_pkg::TK_ERROR) ? cur_q.line : '0;
    out_valid_d = emit ? 1'b1 : (tok_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stt_pkg::ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      kind_q     <= res_kind;
      value_q    <= res_value;
      text_q     <= res_text;
      tlast_q    <= res_tlast;
      err_q      <= res_err;
      line_q     <= res_line;
      run_last_q <= fin;
    end
  end

  assign tok_o.valid       = out_valid_q;
  assign tok_o.token_kind  = kind_q;
  assign tok_o.token_value = value_q;
  assign tok_o.text_char   = text_q;
  assign tok_o.text_last   = tlast_q;
  assign tok_o.error_code  = err_q;
  assign tok_o.error_line  = line_q;
  assign tok_o.run_last    = run_last_q;

endmodule

// ===== hdl/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: source bytes in, tokens out.
//
//   channel  dir  handshake      beat
//   src_i    in   valid/ready    kind, char_byte
//   tok_o    out  valid/ready    token_kind, token_value, text_char,
//                                text_last, error_code, error_line, run_last
//
// the front takes one byte per cycle while the queue has room; the back emits
// one token per cycle while tok_o is ready; an identifier that is not a
// keyword holds src_i after its closing beat until its last character is read
// out; a two-entry command queue lets either side stall on its own
// reset is asynchronous and active low; the word buffer is not cleared
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
  parameter int unsigned MAX_WORD = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    src_i,
  stt_out_if.source tok_o
);

  localparam int unsigned AW = $clog2(MAX_WORD);

  stt_pkg::cmd_t push_cmd, head_cmd;
  logic          push, full, pop, empty, drain_done;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  stt_front #(
    .MAX_WORD (MAX_WORD)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_i        (src_i),
    .full_i       (full),
    .drain_done_i (drain_done),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata)
  );

  stt_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WORD)
  ) u_word_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  stt_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .empty_o (empty)
  );

  stt_back #(
    .MAX_WORD (MAX_WORD)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_cmd),
    .empty_i      (empty),
    .pop_o        (pop),
    .drain_done_o (drain_done),
    .raddr_o      (raddr),
    .rdata_i      (rdata),
    .tok_o        (tok_o)
  );

endmodule
